/* design/rsrd_pkg.sv */
// ============================================================================
// rsrd_pkg
// Shared types, constants and helper functions of the run-length sprite
// decoder.
// ============================================================================
package rsrd_pkg;

	// Largest frame side in pixels.
	localparam int MAX_SIDE = 64;

	localparam int SIDE_W   = 7;   // frame side and segment length width
	localparam int COL_W    = 6;   // column counter width
	localparam int ROW_W    = 7;   // row counter width
	localparam int CANVAS_W = 8;   // canvas size and canvas coordinate width
	localparam int PIX_W    = 16;  // RGB565 value width
	localparam int RUN_W    = 16;  // run length width
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int S_DATA_W = 32;  // pixel_value, run_length
	localparam int M_DATA_W = 40;  // seg_x, seg_y, seg_length, seg_colour, pad

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_KEY = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [SIDE_W-1:0]   RST_FRAME_SIDE  = 7'd64;
	localparam logic [CANVAS_W-1:0] RST_CANVAS_SIDE = 8'd64;
	localparam logic [PIX_W-1:0]    RST_KEY         = 16'd6341;

	localparam logic [4:0] RED_MAX = 5'h1F;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the accepted input word
		logic setup;  // apply frame start and wrap checks
		logic step;   // walk one row segment
	} rsrd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic go;        // run has pixels to walk after setup
		logic last;      // the current step ends the run
		logic out_free;  // output register can take a segment
	} rsrd_status_t;

	// A side of 0 counts as 1 and anything above MAX_SIDE counts as MAX_SIDE.
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Centering offset, rounded down, never negative.
	function automatic logic [SIDE_W-1:0] center_offset(input logic [CANVAS_W-1:0] canvas,
			input logic [SIDE_W-1:0] side);
		logic [CANVAS_W-1:0] diff;
		diff = canvas - {1'b0, side};
		return (canvas > {1'b0, side}) ? diff[CANVAS_W-1:1] : '0;
	endfunction

	// Red up by a quarter with saturation, blue down by a quarter.
	function automatic logic [PIX_W-1:0] warm_colour(input logic [PIX_W-1:0] v);
		logic [5:0] red_sum;
		logic [4:0] red;
		logic [4:0] blue;
		red_sum = {1'b0, v[15:11]} + {3'b000, v[15:13]};
		red = (red_sum > {1'b0, RED_MAX}) ? RED_MAX : red_sum[4:0];
		blue = v[4:0] - {2'b00, v[4:2]};
		return {red, v[10:5], blue};
	endfunction

endpackage

/* design/rsrd_ctrl.sv */
// ============================================================================
// rsrd_ctrl
// Controller of the run-length sprite decoder: accepts a run, sequences the
// setup step and the per-row walk.
// ============================================================================
module rsrd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  rsrd_pkg::rsrd_status_t status,
	output rsrd_pkg::rsrd_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready  = (state_q == ST_IDLE);
	assign cmd.load  = s_tvalid && (state_q == ST_IDLE);
	assign cmd.setup = (state_q == ST_SETUP);
	assign cmd.step  = (state_q == ST_EMIT) && status.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = status.go ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (cmd.step && status.last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/rsrd_datapath.sv */
// ============================================================================
// rsrd_datapath
// Datapath of the run-length sprite decoder: configuration registers, frame
// position, run remainder and the segment output register.
// ============================================================================
module rsrd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rsrd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rsrd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [rsrd_pkg::S_DATA_W-1:0]          s_tdata,
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [rsrd_pkg::M_DATA_W-1:0]          m_tdata,
	output logic                                  m_tlast,
	output logic                                  m_tuser,
	input  rsrd_pkg::rsrd_cmd_t                    cmd,
	output rsrd_pkg::rsrd_status_t                 status
);

	localparam int SW = rsrd_pkg::SIDE_W;
	localparam int CW = rsrd_pkg::COL_W;
	localparam int RW = rsrd_pkg::ROW_W;
	localparam int VW = rsrd_pkg::CANVAS_W;
	localparam int PW = rsrd_pkg::PIX_W;
	localparam int LW = rsrd_pkg::RUN_W;

	// Configuration.
	logic [SW-1:0] frame_width_q;
	logic [SW-1:0] frame_height_q;
	logic [VW-1:0] canvas_width_q;
	logic [VW-1:0] canvas_height_q;
	logic [PW-1:0] key_q;

	// Run and frame position.
	logic          start_q;
	logic [PW-1:0] value_q;
	logic [LW-1:0] rem_q;
	logic [CW-1:0] column_q;
	logic [RW-1:0] row_q;
	logic          done_q;

	// Output register.
	logic          out_valid_q;
	logic [VW-1:0] out_x_q;
	logic [VW-1:0] out_y_q;
	logic [SW-1:0] out_len_q;
	logic [PW-1:0] out_colour_q;
	logic          out_last_q;
	logic          out_complete_q;

	logic [SW-1:0] w;
	logic [SW-1:0] h;
	logic [SW-1:0] ox;
	logic [SW-1:0] oy;
	logic          opaque;

	// Setup terms.
	logic [CW-1:0] s_col;
	logic [RW-1:0] s_row;
	logic          s_done;
	logic          s_wrap;
	logic [RW-1:0] s_row_adj;
	logic          s_past_end;

	// Step terms.
	logic [SW-1:0] room;
	logic [SW-1:0] len;
	logic [SW-1:0] col_sum;
	logic          wrap;
	logic [RW-1:0] row_inc;
	logic          done_n;
	logic [LW-1:0] rem_n;

	assign w      = rsrd_pkg::clamp_side(frame_width_q);
	assign h      = rsrd_pkg::clamp_side(frame_height_q);
	assign ox     = rsrd_pkg::center_offset(canvas_width_q, w);
	assign oy     = rsrd_pkg::center_offset(canvas_height_q, h);
	assign opaque = (value_q != key_q);

	always_comb begin
		s_col      = start_q ? '0 : column_q;
		s_row      = start_q ? '0 : row_q;
		s_done     = start_q ? 1'b0 : done_q;
		s_wrap     = ({1'b0, s_col} >= w);
		s_row_adj  = s_wrap ? s_row + RW'(1) : s_row;
		s_past_end = (s_row_adj >= h);

		room    = w - {1'b0, column_q};
		len     = (rem_q < {{(LW-SW){1'b0}}, room}) ? rem_q[SW-1:0] : room;
		col_sum = {1'b0, column_q} + len;
		wrap    = (col_sum >= w);
		row_inc = row_q + RW'(1);
		done_n  = wrap && (row_inc >= h);
		rem_n   = rem_q - {{(LW-SW){1'b0}}, len};
	end

	assign status.go       = !s_done && (rem_q != '0) && !s_past_end;
	assign status.last     = (rem_n == '0) || done_n;
	assign status.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= rsrd_pkg::RST_FRAME_SIDE;
			frame_height_q  <= rsrd_pkg::RST_FRAME_SIDE;
			canvas_width_q  <= rsrd_pkg::RST_CANVAS_SIDE;
			canvas_height_q <= rsrd_pkg::RST_CANVAS_SIDE;
			key_q           <= rsrd_pkg::RST_KEY;
		end else if (cfg_we) begin
			case (cfg_index)
				rsrd_pkg::REG_FRAME_WIDTH:     frame_width_q   <= cfg_data[SW-1:0];
				rsrd_pkg::REG_FRAME_HEIGHT:    frame_height_q  <= cfg_data[SW-1:0];
				rsrd_pkg::REG_CANVAS_WIDTH:    canvas_width_q  <= cfg_data[VW-1:0];
				rsrd_pkg::REG_CANVAS_HEIGHT:   canvas_height_q <= cfg_data[VW-1:0];
				rsrd_pkg::REG_TRANSPARENT_KEY: key_q           <= cfg_data[PW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			done_q   <= 1'b0;
		end else if (cmd.setup) begin
			if (!s_done && (rem_q != '0)) begin
				column_q <= s_wrap ? '0 : s_col;
				if (s_past_end) begin
					done_q <= 1'b1;
					row_q  <= h;
				end else begin
					done_q <= 1'b0;
					row_q  <= s_row_adj;
				end
			end else begin
				column_q <= s_col;
				row_q    <= s_row;
				done_q   <= s_done;
			end
		end else if (cmd.step) begin
			if (wrap) begin
				column_q <= '0;
				row_q    <= row_inc;
				done_q   <= done_n;
			end else begin
				column_q <= col_sum[CW-1:0];
			end
		end
	end

	// The accepted word and the remaining run length need no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= s_tuser;
			value_q <= s_tdata[PW-1:0];
			rem_q   <= s_tdata[PW+LW-1:PW];
		end else if (cmd.step) begin
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd.step && opaque) || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && opaque) begin
			out_x_q        <= {1'b0, ox} + {2'b00, column_q};
			out_y_q        <= {1'b0, oy} + {1'b0, row_q};
			out_len_q      <= len;
			out_colour_q   <= rsrd_pkg::warm_colour(value_q);
			out_last_q     <= status.last;
			out_complete_q <= done_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_colour_q, out_len_q, out_y_q, out_x_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_complete_q;

endmodule

/* design/rle_sprite_run_decoder.sv */
// ============================================================================
// rle_sprite_run_decoder
// Decodes RGB565 run-length pairs into centered, color-warmed row segments.
// ============================================================================
// The first segment of a run passes through the setup state, then a walk
// step loads it into the output register. A run occupies the block from
// acceptance through setup and its walk until it returns to idle; no new
// run word is taken meanwhile. The walk emits one row per cycle while the output side is free.
// Stalls on the output side hold the walk; transparent runs walk silently.
// Reset (arst_n low) clears the position and frame-done flag and loads the
// configuration defaults: 64x64 frame, 64x64 canvas, key 0x18C5.
module rle_sprite_run_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input run words.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [rsrd_pkg::S_DATA_W-1:0]          s_tdata,  // pixel_value, run_length
	input  logic                                  s_tuser,  // frame_start
	// Output segment words.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [rsrd_pkg::M_DATA_W-1:0]          m_tdata,  // seg_x, seg_y, seg_length,
	                                                         // seg_colour, zero pad
	output logic                                  m_tlast,  // seg_last
	output logic                                  m_tuser,  // frame_complete
	// Configuration writes.
	input  logic                                  cfg_we,
	input  logic [rsrd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rsrd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// The controller only sequences; all arithmetic and state of the frame
	// walk live in the datapath.
	rsrd_pkg::rsrd_cmd_t    cmd;
	rsrd_pkg::rsrd_status_t status;

	// The controller takes a new word only in its idle state. The output
	// register decouples the master side, so a segment still waiting there
	// does not hold off the next run word.
	rsrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Each walk step clips the remaining run to the room left in the current
	// row, advances column and row, and loads a segment when the run is opaque.
	rsrd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* design/rsrd_checker.sv */
// ============================================================================
// rsrd_checker
// Port-level checks of the run-length sprite decoder, bound to the top level.
// ============================================================================
module rsrd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rsrd_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);

	// A stalled segment holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled segment changed");

	// A run is worked on alone: no word is taken right after another.
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted during a run");

	// Segment length is between one pixel and a full row.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[22:16] != 7'd0) && (m_tdata[22:16] <= 7'd64))
		else $error("segment length out of range");

	// The segment that completes the frame is the last of its run.
	a_complete_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame complete without last");

endmodule

bind rle_sprite_run_decoder rsrd_checker u_rsrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
